// ===== rtl/lcsr_pkg.sv =====
// Shared types, widths, reset values and control codes of the load-cell settle-and-report block.
package lcsr_pkg;

  // Field and register widths
  localparam int READING_W = 16;
  localparam int AVG_W     = 15;
  localparam int TOL_W     = 10;
  localparam int ZCNT_W    = 16;
  localparam int PER_W     = 10;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REASON_W  = 2;

  localparam int AVERAGE_DEPTH_DEF = 10;

  // Weights above 2 kg are shown
  localparam logic signed [READING_W-1:0] SHOW_LIMIT = 16'sd200;

  // Register reset values
  localparam logic [TOL_W-1:0]            TOL_RST    = 10'd10;
  localparam logic signed [READING_W-1:0] ZBL_RST    = -16'sd380;
  localparam logic [AVG_W-1:0]            ZBH_RST    = 15'd200;
  localparam logic [ZCNT_W-1:0]           ZLIM_RST   = 16'd1800;
  localparam logic [PER_W-1:0]            PERIOD_RST = 10'd30;
  localparam logic [AVG_W-1:0]            RMIN_RST   = 15'd500;
  localparam logic [AVG_W-1:0]            WL_RST     = 15'd680;
  localparam logic [AVG_W-1:0]            WH_RST     = 15'd780;

  // Register indexes (byte address / 4)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TOL    = 3'd0;
  localparam reg_idx_t REG_ZBL    = 3'd1;
  localparam reg_idx_t REG_ZBH    = 3'd2;
  localparam reg_idx_t REG_ZLIM   = 3'd3;
  localparam reg_idx_t REG_PERIOD = 3'd4;
  localparam reg_idx_t REG_RMIN   = 3'd5;
  localparam reg_idx_t REG_WL     = 3'd6;
  localparam reg_idx_t REG_WH     = 3'd7;

  typedef enum logic [REASON_W-1:0] {
    RSN_PERIODIC = 2'd0,
    RSN_SETTLED  = 2'd1,
    RSN_TARE     = 2'd2
  } reason_t;

  typedef struct packed {
    logic [TOL_W-1:0]            tol;
    logic signed [READING_W-1:0] zbl;
    logic [AVG_W-1:0]            zbh;
    logic [ZCNT_W-1:0]           zlim;
    logic [PER_W-1:0]            period;
    logic [AVG_W-1:0]            rmin;
    logic [AVG_W-1:0]            wl;
    logic [AVG_W-1:0]            wh;
  } cfg_t;

  // Datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_SETTLE,
    OP_ZERO,
    OP_PERIOD,
    OP_PICK,
    OP_WINDOW,
    OP_PUSH,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } op_t;

  // Step sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,       // advance
    C_WAIT_IN,    // hold until an input transaction, then advance
    C_NONE_LEFT,  // jump when no result is pending, else advance
    C_OUT_WIN,    // jump when the weight is outside the window, else advance
    C_DIV_MORE,   // jump while quotient bits remain, else advance
    C_WAIT_OUT    // hold while the output register is full, then jump
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic none_left;
    logic in_window;
    logic div_more;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/lcsr_chan_if.sv =====
// Valid/ready channel interfaces for readings and for report results.
interface lcsr_in_if;
  import lcsr_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface lcsr_out_if;
  import lcsr_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [REASON_W-1:0]         reason;
  logic signed [READING_W-1:0] weight;
  logic                        show_weight;
  logic                        average_valid;
  logic [AVG_W-1:0]            average;
  logic                        tare_request;
  logic                        last_result;

  modport source (output valid, output reason, output weight, output show_weight,
                  output average_valid, output average, output tare_request,
                  output last_result, input ready);
  modport sink   (input valid, input reason, input weight, input show_weight,
                  input average_valid, input average, input tare_request,
                  input last_result, output ready);
endinterface

// ===== rtl/lcsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lcsr_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lcsr_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module lcsr_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  lcsr_pkg::stat_t stat,
  output lcsr_pkg::ctrl_t ctrl
);
  import lcsr_pkg::*;

  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_SETTLE   = 4'd1;
  localparam step_t S_ZERO     = 4'd2;
  localparam step_t S_PERIOD   = 4'd3;
  localparam step_t S_PICK     = 4'd4;
  localparam step_t S_WINDOW   = 4'd5;
  localparam step_t S_PUSH     = 4'd6;
  localparam step_t S_DIV_INIT = 4'd7;
  localparam step_t S_DIV_STEP = 4'd8;
  localparam step_t S_OUT      = 4'd9;

  // Control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    unique case (s)
      S_WAIT:     w = '{op: OP_ACCEPT,   cond: C_WAIT_IN,   target: S_WAIT};
      S_SETTLE:   w = '{op: OP_SETTLE,   cond: C_NEXT,      target: S_WAIT};
      S_ZERO:     w = '{op: OP_ZERO,     cond: C_NEXT,      target: S_WAIT};
      S_PERIOD:   w = '{op: OP_PERIOD,   cond: C_NEXT,      target: S_WAIT};
      S_PICK:     w = '{op: OP_PICK,     cond: C_NONE_LEFT, target: S_WAIT};
      S_WINDOW:   w = '{op: OP_WINDOW,   cond: C_OUT_WIN,   target: S_OUT};
      S_PUSH:     w = '{op: OP_PUSH,     cond: C_NEXT,      target: S_WAIT};
      S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,      target: S_WAIT};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: S_DIV_STEP};
      S_OUT:      w = '{op: OP_OUT,      cond: C_WAIT_OUT,  target: S_PICK};
      default:    w = '{op: OP_ACCEPT,   cond: C_NEXT,      target: S_WAIT};
    endcase
    return w;
  endfunction

  step_t step_r;
  step_t step_nxt;
  step_t step_inc;

  assign step_inc = step_r + 4'd1;

  // Output: control word of the current step
  always_comb begin
    ctrl = ucode(step_r);
  end

  // Next step
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      step_nxt = step_inc;
      C_WAIT_IN:   step_nxt = stat.in_valid ? step_inc : step_r;
      C_NONE_LEFT: step_nxt = stat.none_left ? ctrl.target : step_inc;
      C_OUT_WIN:   step_nxt = stat.in_window ? step_inc : ctrl.target;
      C_DIV_MORE:  step_nxt = stat.div_more ? ctrl.target : step_inc;
      C_WAIT_OUT:  step_nxt = stat.out_busy ? step_r : ctrl.target;
      default:     step_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/lcsr_dp.sv =====
// Datapath: settle and count state, result flags, average store control, divider, output register.
module lcsr_dp #(
  parameter  int AVERAGE_DEPTH = lcsr_pkg::AVERAGE_DEPTH_DEF,
  localparam int IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcsr_pkg::ctrl_t            ctrl,
  output lcsr_pkg::stat_t            stat,
  input  lcsr_pkg::cfg_t             cfg,
  lcsr_in_if.sink                    in_ch,
  lcsr_out_if.source                 out_ch,
  output logic                       ram_we,
  output logic [IDX_W-1:0]           ram_waddr,
  output logic [IDX_W-1:0]           ram_raddr,
  output logic [lcsr_pkg::AVG_W-1:0] ram_wdata,
  input  logic [lcsr_pkg::AVG_W-1:0] ram_rdata
);
  import lcsr_pkg::*;

  localparam int FILL_W = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W  = AVG_W + FILL_W;
  localparam int DVD_W  = SUM_W + 1;
  localparam int QCNT_W = $clog2(AVG_W);

  function automatic logic near(input logic signed [READING_W-1:0] a,
                                input logic signed [READING_W-1:0] b,
                                input logic [TOL_W-1:0] tol);
    logic signed [READING_W:0] d;
    logic [READING_W:0]        mag;
    d   = $signed({a[READING_W-1], a}) - $signed({b[READING_W-1], b});
    mag = d[READING_W] ? $unsigned(-d) : $unsigned(d);
    return mag <= (READING_W + 1)'(tol);
  endfunction

  // Control state
  logic signed [READING_W-1:0] prev_r, prev_nxt;
  logic signed [READING_W-1:0] rep_r, rep_nxt;
  logic [ZCNT_W-1:0]           zh_r, zh_nxt;
  logic [PER_W-1:0]            rc_r, rc_nxt;
  logic                        new_f_r, new_f_nxt;
  logic                        tare_f_r, tare_f_nxt;
  logic                        per_f_r, per_f_nxt;
  logic [IDX_W-1:0]            head_r, head_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [QCNT_W-1:0]           qcnt_r, qcnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Payload
  logic signed [READING_W-1:0] reading_r, reading_nxt;
  reason_t                     reason_r, reason_nxt;
  logic                        tare_r, tare_nxt;
  logic                        last_r, last_nxt;
  logic                        win_r, win_nxt;
  logic [DVD_W-1:0]            rem_r, rem_nxt;
  logic [DVD_W-1:0]            dsh_r, dsh_nxt;
  logic [AVG_W-1:0]            quo_r, quo_nxt;
  reason_t                     o_reason_r, o_reason_nxt;
  logic signed [READING_W-1:0] o_weight_r, o_weight_nxt;
  logic                        o_show_r, o_show_nxt;
  logic                        o_avgv_r, o_avgv_nxt;
  logic [AVG_W-1:0]            o_avg_r, o_avg_nxt;
  logic                        o_tare_r, o_tare_nxt;
  logic                        o_last_r, o_last_nxt;

  // Decisions
  logic              near_prev, near_rep, in_band, in_window, above_min, full, ge, out_busy;
  logic [ZCNT_W:0]   zh_inc;
  logic [PER_W:0]    rc_inc;
  logic [FILL_W:0]   wpos;
  logic [FILL_W:0]   wpos_wrap;
  logic [IDX_W-1:0]  head_adv;
  logic [AVG_W-1:0]  w15;

  assign near_prev = near(reading_r, prev_r, cfg.tol);
  assign near_rep  = near(reading_r, rep_r, cfg.tol);
  assign in_band   = (reading_r <= $signed({1'b0, cfg.zbh})) &&
                     (reading_r >= $signed(cfg.zbl));
  assign in_window = (rep_r > $signed({1'b0, cfg.wl})) && (rep_r < $signed({1'b0, cfg.wh}));
  assign above_min = rep_r > $signed({1'b0, cfg.rmin});
  assign zh_inc    = {1'b0, zh_r} + (ZCNT_W + 1)'(1);
  assign rc_inc    = {1'b0, rc_r} + (PER_W + 1)'(1);
  assign full      = (fill_r == FILL_W'(AVERAGE_DEPTH));
  assign wpos      = (FILL_W + 1)'(head_r) + (FILL_W + 1)'(fill_r);
  assign wpos_wrap = (wpos >= (FILL_W + 1)'(AVERAGE_DEPTH)) ?
                     wpos - (FILL_W + 1)'(AVERAGE_DEPTH) : wpos;
  assign head_adv  = (head_r == IDX_W'(AVERAGE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
  assign w15       = rep_r[AVG_W-1:0];
  assign ge        = rem_r >= dsh_r;
  assign out_busy  = out_valid_r && !out_ch.ready;

  assign stat.in_valid  = in_ch.valid;
  assign stat.none_left = !(new_f_r || tare_f_r || per_f_r);
  assign stat.in_window = in_window;
  assign stat.div_more  = (qcnt_r != '0);
  assign stat.out_busy  = out_busy;

  assign in_ch.ready = (ctrl.op == OP_ACCEPT);
  assign ram_raddr   = head_r;
  assign ram_wdata   = w15;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reason        = o_reason_r;
  assign out_ch.weight        = o_weight_r;
  assign out_ch.show_weight   = o_show_r;
  assign out_ch.average_valid = o_avgv_r;
  assign out_ch.average       = o_avg_r;
  assign out_ch.tare_request  = o_tare_r;
  assign out_ch.last_result   = o_last_r;

  always_comb begin
    prev_nxt      = prev_r;
    rep_nxt       = rep_r;
    zh_nxt        = zh_r;
    rc_nxt        = rc_r;
    new_f_nxt     = new_f_r;
    tare_f_nxt    = tare_f_r;
    per_f_nxt     = per_f_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    qcnt_nxt      = qcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    reading_nxt   = reading_r;
    reason_nxt    = reason_r;
    tare_nxt      = tare_r;
    last_nxt      = last_r;
    win_nxt       = win_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    o_reason_nxt  = o_reason_r;
    o_weight_nxt  = o_weight_r;
    o_show_nxt    = o_show_r;
    o_avgv_nxt    = o_avgv_r;
    o_avg_nxt     = o_avg_r;
    o_tare_nxt    = o_tare_r;
    o_last_nxt    = o_last_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;

    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (in_ch.valid) begin
          reading_nxt = in_ch.reading;
        end
      end
      OP_SETTLE: begin
        if (near_prev) begin
          if (!near_rep) begin
            rep_nxt   = reading_r;
            zh_nxt    = '0;
            new_f_nxt = 1'b1;
          end
        end else begin
          prev_nxt = reading_r;
        end
      end
      OP_ZERO: begin
        if (in_band) begin
          if (zh_inc > {1'b0, cfg.zlim}) begin
            zh_nxt     = '0;
            tare_f_nxt = 1'b1;
          end else begin
            zh_nxt = zh_inc[ZCNT_W-1:0];
          end
        end
      end
      OP_PERIOD: begin
        if (rc_inc > {1'b0, cfg.period}) begin
          rc_nxt    = '0;
          per_f_nxt = above_min;
        end else begin
          rc_nxt = rc_inc[PER_W-1:0];
        end
      end
      OP_PICK: begin
        priority if (new_f_r) begin
          new_f_nxt  = 1'b0;
          reason_nxt = RSN_SETTLED;
          tare_nxt   = 1'b0;
          last_nxt   = !(tare_f_r || per_f_r);
        end else if (tare_f_r) begin
          tare_f_nxt = 1'b0;
          reason_nxt = RSN_TARE;
          tare_nxt   = 1'b1;
          last_nxt   = !per_f_r;
        end else if (per_f_r) begin
          per_f_nxt  = 1'b0;
          reason_nxt = RSN_PERIODIC;
          tare_nxt   = 1'b0;
          last_nxt   = 1'b1;
        end
      end
      OP_WINDOW: begin
        win_nxt = in_window;
      end
      OP_PUSH: begin
        ram_we = 1'b1;
        if (full) begin
          // Drop the oldest entry, which sits at the head
          ram_waddr = head_r;
          head_nxt  = head_adv;
          sum_nxt   = sum_r - SUM_W'(ram_rdata) + SUM_W'(w15);
        end else begin
          ram_waddr = wpos_wrap[IDX_W-1:0];
          fill_nxt  = fill_r + FILL_W'(1);
          sum_nxt   = sum_r + SUM_W'(w15);
        end
      end
      OP_DIV_INIT: begin
        // (2*sum + fill) / (2*fill) rounds half up
        rem_nxt  = {sum_r, 1'b0} + DVD_W'(fill_r);
        dsh_nxt  = DVD_W'({fill_r, 1'b0}) << (AVG_W - 1);
        quo_nxt  = '0;
        qcnt_nxt = QCNT_W'(AVG_W - 1);
      end
      OP_DIV_STEP: begin
        rem_nxt = ge ? rem_r - dsh_r : rem_r;
        quo_nxt = {quo_r[AVG_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        if (qcnt_r != '0) begin
          qcnt_nxt = qcnt_r - QCNT_W'(1);
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          o_reason_nxt  = reason_r;
          o_weight_nxt  = rep_r;
          o_show_nxt    = rep_r > SHOW_LIMIT;
          o_avgv_nxt    = win_r;
          o_avg_nxt     = win_r ? quo_r : '0;
          o_tare_nxt    = tare_r;
          o_last_nxt    = last_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      rep_r       <= '0;
      zh_r        <= '0;
      rc_r        <= '0;
      new_f_r     <= 1'b0;
      tare_f_r    <= 1'b0;
      per_f_r     <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      rep_r       <= rep_nxt;
      zh_r        <= zh_nxt;
      rc_r        <= rc_nxt;
      new_f_r     <= new_f_nxt;
      tare_f_r    <= tare_f_nxt;
      per_f_r     <= per_f_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reading_r  <= reading_nxt;
    reason_r   <= reason_nxt;
    tare_r     <= tare_nxt;
    last_r     <= last_nxt;
    win_r      <= win_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quo_r      <= quo_nxt;
    o_reason_r <= o_reason_nxt;
    o_weight_r <= o_weight_nxt;
    o_show_r   <= o_show_nxt;
    o_avgv_r   <= o_avgv_nxt;
    o_avg_r    <= o_avg_nxt;
    o_tare_r   <= o_tare_nxt;
    o_last_r   <= o_last_nxt;
  end

endmodule

// ===== rtl/load_cell_settle_and_report.sv =====
// Top level of the load-cell settle-and-report block with its configuration registers.
//
// Takes one averaged load-cell reading (signed hundredths of a kilogram) per input
// transaction and produces zero to three report transactions, in the order new settled
// weight, auto-tare request, periodic re-report; last_result marks the final one of a
// reading. Reports whose weight lies strictly between window_low and window_high are
// pushed into a moving average of up to AVERAGE_DEPTH entries (a ring in a small RAM),
// and carry its mean rounded half up. Control is a ten-step microprogram: one step takes
// the reading, three steps evaluate settling, the zero-band count and the report period,
// and then each report runs pick and window check, then, inside the window only, push,
// divider setup and fifteen restoring divide steps, and last the output load. The
// divider, shared by all reports, works out one quotient bit per cycle. The output register
// holds a finished report while the next reading is taken, but a report stalls the
// program while the previous one is still waiting on out_chan.ready. Registers sit on an
// APB port at byte address 4*i; the user must write them only while the block is idle,
// and the block itself does not enforce this.
module load_cell_settle_and_report #(
  parameter int AVERAGE_DEPTH = lcsr_pkg::AVERAGE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lcsr_in_if.sink                     in_chan,
  lcsr_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcsr_pkg::ADDR_W-1:0] paddr,
  input  logic [lcsr_pkg::DATA_W-1:0] pwdata,
  output logic [lcsr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lcsr_pkg::*;

  localparam int IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

  cfg_t             cfg_r, cfg_nxt;
  reg_idx_t         reg_idx;
  ctrl_t            ctrl;
  stat_t            stat;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [AVG_W-1:0] ram_wdata;
  logic [AVG_W-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register write: take the access phase of a write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_TOL:    cfg_nxt.tol    = pwdata[TOL_W-1:0];
        REG_ZBL:    cfg_nxt.zbl    = pwdata[READING_W-1:0];
        REG_ZBH:    cfg_nxt.zbh    = pwdata[AVG_W-1:0];
        REG_ZLIM:   cfg_nxt.zlim   = pwdata[ZCNT_W-1:0];
        REG_PERIOD: cfg_nxt.period = pwdata[PER_W-1:0];
        REG_RMIN:   cfg_nxt.rmin   = pwdata[AVG_W-1:0];
        REG_WL:     cfg_nxt.wl     = pwdata[AVG_W-1:0];
        REG_WH:     cfg_nxt.wh     = pwdata[AVG_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register read-back, zero-extended except for the signed zbl, which is sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_TOL:    prdata = DATA_W'(cfg_r.tol);
      REG_ZBL:    prdata = DATA_W'(cfg_r.zbl);
      REG_ZBH:    prdata = DATA_W'(cfg_r.zbh);
      REG_ZLIM:   prdata = DATA_W'(cfg_r.zlim);
      REG_PERIOD: prdata = DATA_W'(cfg_r.period);
      REG_RMIN:   prdata = DATA_W'(cfg_r.rmin);
      REG_WL:     prdata = DATA_W'(cfg_r.wl);
      REG_WH:     prdata = DATA_W'(cfg_r.wh);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol    <= TOL_RST;
      cfg_r.zbl    <= ZBL_RST;
      cfg_r.zbh    <= ZBH_RST;
      cfg_r.zlim   <= ZLIM_RST;
      cfg_r.period <= PERIOD_RST;
      cfg_r.rmin   <= RMIN_RST;
      cfg_r.wl     <= WL_RST;
      cfg_r.wh     <= WH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Microprogram sequencer
  lcsr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath driven by the current control word
  lcsr_dp #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg       (cfg_r),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Moving-average ring; entries past the fill count are never used
  lcsr_ram #(
    .WIDTH (AVG_W),
    .DEPTH (AVERAGE_DEPTH)
  ) u_avg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
